[src/mat3_pkg.sv]
// Shared constants and types for the 3x3 matrix add, multiply and compare block.
package mat3_pkg;

    localparam int DIM_DEFAULT       = 3;
    localparam int ELEM_BITS_DEFAULT = 16;

    // Fixed field widths of the load and result items.
    localparam int IDX_FIELD_BITS = 2;
    localparam int VALUE_BITS     = 16;
    localparam int SUM_BITS       = 17;
    localparam int PROD_BITS      = 33;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_EMIT
    } mat3_state_t;

endpackage

[src/mat3_in_if.sv]
// Load channel: one matrix element per item, with valid/ready handshake.
interface mat3_in_if;
    import mat3_pkg::*;

    logic                           valid;
    logic                           ready;
    logic                           matrix_sel;
    logic [IDX_FIELD_BITS-1:0]      row;
    logic [IDX_FIELD_BITS-1:0]      col;
    logic signed [VALUE_BITS-1:0]   value;
    logic                           complete;

    modport source
    (
        output valid, matrix_sel, row, col, value, complete,
        input  ready
    );

    modport sink
    (
        input  valid, matrix_sel, row, col, value, complete,
        output ready
    );
endinterface

[src/mat3_out_if.sv]
// Result channel: one element of A+B and A*B per item, with valid/ready handshake.
interface mat3_out_if;
    import mat3_pkg::*;

    logic                           valid;
    logic                           ready;
    logic [IDX_FIELD_BITS-1:0]      out_row;
    logic [IDX_FIELD_BITS-1:0]      out_col;
    logic signed [SUM_BITS-1:0]     sum_elem;
    logic signed [PROD_BITS-1:0]    product_elem;
    logic                           all_equal;
    logic                           last;

    modport source
    (
        output valid, out_row, out_col, sum_elem, product_elem, all_equal, last,
        input  ready
    );

    modport sink
    (
        input  valid, out_row, out_col, sum_elem, product_elem, all_equal, last,
        output ready
    );
endinterface

[src/mat3_store.sv]
// Element store for one matrix: one write port, two registered read ports.
module mat3_store #(
    parameter int DIM       = mat3_pkg::DIM_DEFAULT,
    parameter int ELEM_BITS = mat3_pkg::ELEM_BITS_DEFAULT,
    parameter int IDX_W     = $clog2(DIM * DIM)
)
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [IDX_W-1:0]            wr_idx,
    input  logic signed [ELEM_BITS-1:0] wr_data,
    input  logic [IDX_W-1:0]            rd0_idx,
    input  logic [IDX_W-1:0]            rd1_idx,
    output logic signed [ELEM_BITS-1:0] rd0_data,
    output logic signed [ELEM_BITS-1:0] rd1_data
);
    import mat3_pkg::*;

    localparam int DEPTH = DIM * DIM;

    logic signed [ELEM_BITS-1:0] mem [DEPTH];
    logic signed [ELEM_BITS-1:0] rd0_data_reg;
    logic signed [ELEM_BITS-1:0] rd1_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd0_data_reg <= mem[rd0_idx];
        rd1_data_reg <= mem[rd1_idx];
    end

    assign rd0_data = rd0_data_reg;
    assign rd1_data = rd1_data_reg;

endmodule

[src/matrix3_add_mul_compare.sv]
// Each result element takes DIM passes of read, multiply and accumulate through one shared
// multiplier, then the emit state loads the output register, waiting while a result is unaccepted.
// A burst holds DIM*DIM results; a load without complete is taken while the block is idle.
// Reset clears the sequencer and the output valid flag; the element stores are undefined
// until written.
module matrix3_add_mul_compare #(
    parameter int DIM       = mat3_pkg::DIM_DEFAULT,
    parameter int ELEM_BITS = mat3_pkg::ELEM_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    mat3_in_if.sink     load,
    mat3_out_if.source  result
);
    import mat3_pkg::*;

    localparam int IDX_W = $clog2(DIM * DIM);
    localparam int CNT_W = $clog2(DIM);

    mat3_state_t state_reg, state_next;

    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             eq_reg, eq_next;
    logic             out_valid_reg, out_valid_next;

    logic signed [2*ELEM_BITS-1:0] prod_reg;
    logic signed [PROD_BITS-1:0]   acc_reg, acc_next;
    logic signed [SUM_BITS-1:0]    sum_reg;

    logic [IDX_FIELD_BITS-1:0]     out_row_reg;
    logic [IDX_FIELD_BITS-1:0]     out_col_reg;
    logic signed [SUM_BITS-1:0]    out_sum_reg;
    logic signed [PROD_BITS-1:0]   out_prod_reg;
    logic                          out_eq_reg;
    logic                          out_last_reg;

    logic                          load_ready;
    logic                          load_fire;
    logic                          in_range;
    logic                          out_load;
    logic                          at_last;
    logic                          k_last;

    logic [IDX_W-1:0]              wr_idx;
    logic signed [ELEM_BITS-1:0]   wr_data;
    logic [IDX_W-1:0]              a_mul_idx;
    logic [IDX_W-1:0]              b_mul_idx;
    logic [IDX_W-1:0]              elem_idx;
    logic signed [ELEM_BITS-1:0]   a_mul;
    logic signed [ELEM_BITS-1:0]   b_mul;
    logic signed [ELEM_BITS-1:0]   a_elem;
    logic signed [ELEM_BITS-1:0]   b_elem;
    logic signed [PROD_BITS-1:0]   prod_ext;

    assign load_fire = load.valid && load_ready;
    assign in_range  = (int'(load.row) < DIM) && (int'(load.col) < DIM);
    assign wr_idx    = IDX_W'(int'(load.row) * DIM + int'(load.col));
    // The low ELEM_BITS of the field are kept and read back as a signed element.
    assign wr_data   = ELEM_BITS'($unsigned(load.value));

    assign a_mul_idx = IDX_W'(int'(i_reg) * DIM + int'(k_reg));
    assign b_mul_idx = IDX_W'(int'(k_reg) * DIM + int'(j_reg));
    assign elem_idx  = IDX_W'(int'(i_reg) * DIM + int'(j_reg));

    assign k_last    = (k_reg == CNT_W'(DIM - 1));
    assign at_last   = (i_reg == CNT_W'(DIM - 1)) && (j_reg == CNT_W'(DIM - 1));
    assign prod_ext  = PROD_BITS'(prod_reg);

    mat3_store #(
        .DIM       (DIM),
        .ELEM_BITS (ELEM_BITS),
        .IDX_W     (IDX_W)
    ) u_left (
        .clk      (clk),
        .wr_en    (load_fire && in_range && !load.matrix_sel),
        .wr_idx   (wr_idx),
        .wr_data  (wr_data),
        .rd0_idx  (a_mul_idx),
        .rd1_idx  (elem_idx),
        .rd0_data (a_mul),
        .rd1_data (a_elem)
    );

    mat3_store #(
        .DIM       (DIM),
        .ELEM_BITS (ELEM_BITS),
        .IDX_W     (IDX_W)
    ) u_right (
        .clk      (clk),
        .wr_en    (load_fire && in_range && load.matrix_sel),
        .wr_idx   (wr_idx),
        .wr_data  (wr_data),
        .rd0_idx  (b_mul_idx),
        .rd1_idx  (elem_idx),
        .rd0_data (b_mul),
        .rd1_data (b_elem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            eq_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            eq_reg        <= eq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        eq_next        = eq_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !result.ready;
        load_ready     = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                load_ready = 1'b1;
                if (load.valid && load.complete)
                begin
                    state_next = ST_READ;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    eq_next    = 1'b1;
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // The element pair at (i, j) is compared once, on the first term.
                if (k_reg == '0)
                begin
                    eq_next = eq_reg && (a_elem == b_elem);
                end
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next = (k_reg == '0) ? prod_ext : acc_reg + prod_ext;
                if (k_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    k_next         = '0;
                    if (at_last)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                        if (j_reg == CNT_W'(DIM - 1))
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (state_reg == ST_MUL)
        begin
            prod_reg <= a_mul * b_mul;
            if (k_reg == '0)
            begin
                sum_reg <= SUM_BITS'(a_elem) + SUM_BITS'(b_elem);
            end
        end
        if (out_load)
        begin
            out_row_reg  <= IDX_FIELD_BITS'(i_reg);
            out_col_reg  <= IDX_FIELD_BITS'(j_reg);
            out_sum_reg  <= sum_reg;
            out_prod_reg <= acc_reg;
            out_eq_reg   <= at_last && eq_reg;
            out_last_reg <= at_last;
        end
    end

    assign load.ready          = load_ready;
    assign result.valid        = out_valid_reg;
    assign result.out_row      = out_row_reg;
    assign result.out_col      = out_col_reg;
    assign result.sum_elem     = out_sum_reg;
    assign result.product_elem = out_prod_reg;
    assign result.all_equal    = out_eq_reg;
    assign result.last         = out_last_reg;

`ifndef NO_ASSERTIONS
    a_start_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (load.valid && load.ready && load.complete) |=> (state_reg == ST_READ))
        else $error("completing load did not start the result burst");

    a_equal_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.all_equal) |-> result.last)
        else $error("equality flag shown on an item other than the last");

    a_emit_after_terms: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> k_last)
        else $error("result emitted before all terms were accumulated");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && at_last) |=> (state_reg == ST_IDLE && result.valid && result.last))
        else $error("final item did not return the sequencer to idle");
`endif

endmodule
